[hdl/fdte_pkg.sv]
package fdte_pkg;

  // One input transfer: the same pixel from the unlit and the lit frame.
  typedef struct packed {
    logic       kind;
    logic [7:0] off_blue;
    logic [7:0] off_green;
    logic [7:0] off_red;
    logic [7:0] on_blue;
    logic [7:0] on_green;
    logic [7:0] on_red;
    logic       in_mask;
  } in_t;

  // One result transfer.
  typedef struct packed {
    logic foreground;
    logic frame_last;
  } out_t;

  // Per-item control worked out when the item enters the pipeline.
  typedef struct packed {
    logic emit;
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic last;
  } win_ctl_t;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_DIFF_THRESHOLD = 2'd2
  } cfg_reg_t;

  localparam logic        KIND_FLUSH     = 1'b1;
  localparam logic [11:0] MAX_HEIGHT     = 12'd2048;
  localparam int          WIDTH_RESET    = 640;
  localparam logic [11:0] HEIGHT_RESET   = 12'd480;
  localparam logic [7:0]  THRESH_RESET   = 8'd80;

  // BT.601 weights in 14-bit fixed point, plus the rounding term.
  localparam logic [13:0] W_BLUE         = 14'd1868;
  localparam logic [13:0] W_GREEN        = 14'd9617;
  localparam logic [13:0] W_RED          = 14'd4899;
  localparam logic [21:0] GREY_ROUND     = 22'd8192;

  // Window bit groups: three bits per column, oldest column in the low bits.
  localparam logic [8:0]  ALL_NINE       = 9'h1FF;
  localparam logic [8:0]  MASK_LEFT      = 9'h007;
  localparam logic [8:0]  MASK_RIGHT     = 9'h1C0;
  localparam logic [8:0]  MASK_TOP       = 9'h049;
  localparam logic [8:0]  MASK_BOTTOM    = 9'h124;

endpackage

[hdl/frame_difference_threshold_erode.sv]
// Frame difference, binary threshold and 3x3 erosion over a raster pixel stream.
// Each input transfer carries one pixel of an unlit and of a lit frame plus a mask
// bit; both are reduced to BT.601 grey, their absolute difference is compared with
// diff_threshold, and the resulting binary map is eroded with a 3x3 rectangle in
// which neighbors outside the frame count as foreground. The block takes one item
// per clock when the result side keeps up. An item passes three pipeline stages
// (grey, threshold, window) and then the output register, which raises out_valid
// for a pixel when the item that completes its window leaves the window stage and
// holds the result until it is taken. That item comes
// frame_width + 1 items after the pixel itself, so after the last pixel the source
// sends frame_width + 1 flush transfers (kind = 1) to drain the frame; frame_last
// marks the final result. A flush sent before all pixels of the frame is dropped,
// and a pixel sent after them counts as a flush. The two line stores share one
// single-port-read, single-port-write memory of MAX_WIDTH two-bit entries, read
// one stage ahead of its write-back with forwarding between adjacent items; it
// needs no clearing because rows above the frame are forced to foreground.
// Writing frame_width or frame_height restarts the frame; diff_threshold applies
// at once. Configuration is taken on any cycle (cfg_ready stays high) but must
// only be written while the block is idle.
module frame_difference_threshold_erode
  import fdte_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,

  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > 12) ? AW + 1 : 12;
  localparam int WIDTH_START = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;
  localparam logic [AW-1:0] WM1_RESET = AW'(WIDTH_START - 1);

  // Configuration is kept in its effective form: the last column index and
  // the clamped height.
  logic [AW-1:0] wm1_r;
  logic [11:0]   h_r;
  logic [7:0]    thresh_r;
  logic [AW-1:0] wm1_cfg;
  logic [11:0]   h_cfg;
  logic [CW-1:0] fw_ext;
  logic          cfg_wr;
  logic          restart;

  // Raster position of the next item, including the virtual positions past
  // the frame that flush transfers fill.
  logic [AW-1:0] col_cnt_r;
  logic [11:0]   row_cnt_r;
  logic [AW-1:0] col_cnt_nxt;
  logic [11:0]   row_cnt_nxt;

  logic          frame_done;
  logic          ignore;
  logic          take;
  logic          col_zero;
  win_ctl_t      ctl;

  // Stage 1: input registers, grey computed from them.
  logic          s1_v_r;
  in_t           s1_pix_r;
  logic          s1_force_r;
  win_ctl_t      s1_ctl_r;
  logic [AW-1:0] s1_addr_r;
  logic [7:0]    grey_off;
  logic [7:0]    grey_on;

  // Stage 2: greys, threshold compared from them; line memory read on exit.
  logic          s2_v_r;
  logic [7:0]    s2_goff_r;
  logic [7:0]    s2_gon_r;
  logic          s2_force_r;
  win_ctl_t      s2_ctl_r;
  logic [AW-1:0] s2_addr_r;
  logic [7:0]    grey_diff;
  logic          bin_val;

  // Stage 3: binary pixel meets line memory data, window shifts on exit.
  logic          s3_v_r;
  logic          s3_bin_r;
  win_ctl_t      s3_ctl_r;
  logic [AW-1:0] s3_addr_r;
  logic [1:0]    lb_rd_data;
  logic [2:0]    col_bits;
  logic [8:0]    window_r;
  logic [8:0]    window_nxt;
  logic [8:0]    win_masked;

  logic          out_valid_r;
  out_t          out_data_r;

  logic          out_free;
  logic          s3_go;
  logic          s3_free;
  logic          s2_go;
  logic          s2_free;
  logic          s1_go;
  logic          s1_free;

  function automatic logic [7:0] grey_of(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r);
    logic [21:0] acc;
    acc = 22'(b) * 22'(W_BLUE) + 22'(g) * 22'(W_GREEN) + 22'(r) * 22'(W_RED)
          + GREY_ROUND;
    return acc[21:14];
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration port. Width and height are clamped as they are written.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign fw_ext    = CW'(cfg_wdata);

  always_comb begin
    if (cfg_wdata == 12'd0) begin
      wm1_cfg = '0;
    end else if (fw_ext > CW'(MAX_WIDTH)) begin
      wm1_cfg = AW'(MAX_WIDTH - 1);
    end else begin
      wm1_cfg = AW'(fw_ext - CW'(1));
    end
  end

  always_comb begin
    if (cfg_wdata == 12'd0) begin
      h_cfg = 12'd1;
    end else if (cfg_wdata > MAX_HEIGHT) begin
      h_cfg = MAX_HEIGHT;
    end else begin
      h_cfg = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r    <= WM1_RESET;
      h_r      <= HEIGHT_RESET;
      thresh_r <= THRESH_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:    wm1_r    <= wm1_cfg;
        REG_FRAME_HEIGHT:   h_r      <= h_cfg;
        REG_DIFF_THRESHOLD: thresh_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // A new frame size starts a fresh frame.
  assign restart = cfg_wr && ((cfg_index == REG_FRAME_WIDTH) ||
                              (cfg_index == REG_FRAME_HEIGHT));

  // ---------------------------------------------------------------------------
  // Pipeline flow. Each stage moves when the stage after it is empty or moving,
  // so bubbles close up and input keeps flowing into empty stages while a result
  // waits. An item that produces no result leaves stage 3 without touching the output.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_r || !out_stall;
  assign s3_go    = s3_v_r && (!s3_ctl_r.emit || out_free);
  assign s3_free  = !s3_v_r || s3_go;
  assign s2_go    = s2_v_r && s3_free;
  assign s2_free  = !s2_v_r || s2_go;
  assign s1_go    = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s1_go;
  assign in_stall = !s1_free;

  // ---------------------------------------------------------------------------
  // Entry: raster position, window edge flags and the end-of-frame mark. The
  // output pixel of an item lies one row up and one column left; for the first
  // column it is the last column two rows up.
  // ---------------------------------------------------------------------------
  assign frame_done = row_cnt_r >= h_r;
  assign ignore     = !frame_done && (in_data.kind == KIND_FLUSH);
  assign take       = in_valid && !in_stall && !ignore;
  assign col_zero   = col_cnt_r == '0;

  always_comb begin
    ctl.emit = (row_cnt_r >= 12'd2) || ((row_cnt_r == 12'd1) && !col_zero);
    if (col_zero) begin
      ctl.left   = wm1_r == '0;
      ctl.right  = 1'b1;
      ctl.top    = row_cnt_r == 12'd2;
      ctl.bottom = (row_cnt_r - 12'd1) >= h_r;
      ctl.last   = ctl.emit && (row_cnt_r == h_r + 12'd1);
    end else begin
      ctl.left   = col_cnt_r == AW'(1);
      ctl.right  = 1'b0;
      ctl.top    = row_cnt_r == 12'd1;
      ctl.bottom = frame_done;
      ctl.last   = 1'b0;
    end
  end

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (restart) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (take) begin
      if (ctl.last) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = '0;
      end else if (col_cnt_r == wm1_r) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = row_cnt_r + 12'd1;
      end else begin
        col_cnt_nxt = col_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: greys of both frames. A masked-out pixel is black in both.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_pix_r   <= in_data;
      s1_force_r <= frame_done;
      s1_ctl_r   <= ctl;
      s1_addr_r  <= col_cnt_r;
    end
  end

  assign grey_off = s1_pix_r.in_mask ?
                    grey_of(s1_pix_r.off_blue, s1_pix_r.off_green, s1_pix_r.off_red) : 8'd0;
  assign grey_on  = s1_pix_r.in_mask ?
                    grey_of(s1_pix_r.on_blue, s1_pix_r.on_green, s1_pix_r.on_red) : 8'd0;

  // ---------------------------------------------------------------------------
  // Stage 2: threshold. Items past the last row are foreground fill.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_free) begin
      s2_v_r <= s1_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_goff_r  <= grey_off;
      s2_gon_r   <= grey_on;
      s2_force_r <= s1_force_r;
      s2_ctl_r   <= s1_ctl_r;
      s2_addr_r  <= s1_addr_r;
    end
  end

  assign grey_diff = (s2_gon_r > s2_goff_r) ? (s2_gon_r - s2_goff_r)
                                            : (s2_goff_r - s2_gon_r);
  assign bin_val   = s2_force_r || (grey_diff > thresh_r);

  // ---------------------------------------------------------------------------
  // Stage 3: the column of three binary pixels is formed from the line memory
  // and the new pixel, the window shifts, and the memory entry is rewritten
  // with the rows moved up by one.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_free) begin
      s3_v_r <= s2_go;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_bin_r  <= bin_val;
      s3_ctl_r  <= s2_ctl_r;
      s3_addr_r <= s2_addr_r;
    end
  end

  fdte_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_linebuf (
    .clk     (clk),
    .rd_en   (s2_go),
    .rd_addr (s2_addr_r),
    .wr_en   (s3_go),
    .wr_addr (s3_addr_r),
    .wr_data ({lb_rd_data[0], s3_bin_r}),
    .rd_data (lb_rd_data)
  );

  // Column bits, from the low bit: two rows up, one row up, current row.
  assign col_bits   = {s3_bin_r, lb_rd_data[0], lb_rd_data[1]};
  assign window_nxt = {col_bits, window_r[8:3]};

  always_comb begin
    win_masked = window_nxt;
    if (s3_ctl_r.left) begin
      win_masked = win_masked | MASK_LEFT;
    end
    if (s3_ctl_r.right) begin
      win_masked = win_masked | MASK_RIGHT;
    end
    if (s3_ctl_r.top) begin
      win_masked = win_masked | MASK_TOP;
    end
    if (s3_ctl_r.bottom) begin
      win_masked = win_masked | MASK_BOTTOM;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= ALL_NINE;
    end else if (restart) begin
      window_r <= ALL_NINE;
    end else if (s3_go) begin
      window_r <= window_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_go && s3_ctl_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go && s3_ctl_r.emit) begin
      out_data_r.foreground <= win_masked == ALL_NINE;
      out_data_r.frame_last <= s3_ctl_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The column position never runs past the last column of the row.
  assert property (@(posedge clk) disable iff (!rst_n) col_cnt_r <= wm1_r)
    else $error("column count beyond frame width");

  // Flush positions reach at most row h_r + 1, the second row past the frame.
  assert property (@(posedge clk) disable iff (!rst_n) row_cnt_r <= h_r + 12'd1)
    else $error("row count beyond frame height plus one");

  // The item that closes the frame puts the raster position back to the start.
  assert property (@(posedge clk) disable iff (!rst_n)
                   take && ctl.last && !restart |=> col_cnt_r == '0 && row_cnt_r == '0)
    else $error("frame did not restart after its last result");

  // A result leaves stage 3 only when the output register can take it.
  assert property (@(posedge clk) disable iff (!rst_n)
                   s3_go && s3_ctl_r.emit |-> out_free)
    else $error("result overwrote a pending output");

endmodule

[hdl/fdte_linebuf.sv]
module fdte_linebuf #(
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [1:0]               wr_data,
  output logic [1:0]               rd_data
);

  // Each entry holds {row two above, row one above} for one column.
  logic [1:0]    mem [DEPTH];
  logic [1:0]    mem_q_r;
  logic          fwd_r;
  logic [1:0]    fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // A read that meets a write to the same entry in the same cycle takes the new data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : mem_q_r;

endmodule
